>>> design/kvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types and codes for the key/value table.
// ----------------------------------------------------------------------------
package kvt_pkg;

    localparam int KVT_IDX_MAX_W = 10;

    localparam logic [1:0] CMD_SEARCH = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } kvt_state_t;

    // running scan outcome, indices zero-extended to the widest table
    typedef struct packed {
        logic                     hit;
        logic [KVT_IDX_MAX_W-1:0] hit_idx;
        logic [31:0]              hit_value;
        logic                     free;
        logic [KVT_IDX_MAX_W-1:0] free_idx;
    } kvt_scan_t;

endpackage

>>> design/key_value_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_table_top
// Bounded table of unique key/value pairs: search, add if absent, delete.
// ----------------------------------------------------------------------------
//  channel   | dir | tdata                        | tuser
//  s_axis    | in  | key[31:0], value[63:32]      | cmd[1:0]
//  m_axis    | out | stored_value[31:0]           | found[0], full_drop[1]
//
//  An item is accepted in the idle state; the slot RAM read port then scans
//  one slot per cycle, then the update state writes the slot and loads the
//  result register. The next item is taken only once the block is back in
//  the idle state, so a new item never starts before the last one is done.
//  After reset every RAM slot is cleared before the first item.
//  A result waiting on m_axis holds the next item in its last cycle.
// ----------------------------------------------------------------------------
module key_value_table_top
    import kvt_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // key, value
    input  logic [1:0]  s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // stored_value
    output logic [1:0]  m_axis_tuser    // found, full_drop
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    // slot word: used, key, value
    logic [64:0] mem [CAPACITY];
    logic [64:0] rd_word_reg;

    kvt_state_t       state_reg, state_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic             chk_reg, chk_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic [1:0]       cmd_reg;
    logic [31:0]      key_reg;
    logic [31:0]      value_reg;
    logic             out_valid_reg, out_valid_next;
    logic [31:0]      out_data_reg;
    logic [1:0]       out_user_reg;

    logic             accept;
    logic             finish;
    logic             start;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [64:0]      mem_wdata;
    logic             drop;
    kvt_scan_t        status;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign start  = accept;

    kvt_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .chk_valid (chk_reg),
        .chk_idx   (chk_idx_reg),
        .rd_used   (rd_word_reg[64]),
        .rd_key    (rd_word_reg[63:32]),
        .rd_value  (rd_word_reg[31:0]),
        .key       (key_reg),
        .status    (status)
    );

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        chk_next       = 1'b0;
        chk_idx_next   = chk_idx_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        s_axis_tready  = 1'b0;
        finish         = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = addr_reg;
        mem_wdata      = '0;
        drop           = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (addr_reg == LAST_IDX)
                begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + IDX_W'(1);
                end
            end
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                addr_next     = '0;
                if (s_axis_tvalid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                chk_next     = 1'b1;
                chk_idx_next = addr_reg;
                if (addr_reg == LAST_IDX)
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    addr_next = addr_reg + IDX_W'(1);
                end
            end
            ST_UPDATE:
            begin
                chk_next = 1'b1;
                finish   = !out_valid_reg || m_axis_tready;
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        mem_waddr = status.free_idx[IDX_W-1:0];
                        mem_wdata = {1'b1, key_reg, value_reg};
                        mem_we    = finish && !status.hit && status.free;
                        drop      = !status.hit && !status.free;
                    end
                    CMD_DELETE:
                    begin
                        mem_waddr = status.hit_idx[IDX_W-1:0];
                        mem_wdata = {1'b0, key_reg, value_reg};
                        mem_we    = finish && status.hit;
                    end
                    CMD_SEARCH:
                    begin
                        mem_we = 1'b0;
                    end
                    default:
                    begin
                        mem_we = 1'b0;
                    end
                endcase
                if (finish)
                begin
                    chk_next       = 1'b0;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            addr_reg      <= '0;
            chk_reg       <= 1'b0;
            chk_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            chk_reg       <= chk_next;
            chk_idx_reg   <= chk_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= s_axis_tuser;
            key_reg   <= s_axis_tdata[31:0];
            value_reg <= s_axis_tdata[63:32];
        end
        if (finish)
        begin
            out_data_reg <= status.hit ? status.hit_value : 32'd0;
            out_user_reg <= {drop, status.hit};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_word_reg <= mem[addr_reg];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

`ifndef SYNTHESIS
    a_rise_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_UPDATE))
        else $error("result appeared outside the update cycle");

    a_drop_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("dropped add reported as found");

    a_miss_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 32'd0))
        else $error("miss with nonzero data");

    a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_SCAN) && (addr_reg == '0) && !chk_reg)
        else $error("accepted item did not start a scan at slot zero");
`endif

endmodule

>>> design/kvt_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_scan
// Slot compare unit: checks one slot per cycle and keeps the first match
// and the lowest free slot seen so far.
// ----------------------------------------------------------------------------
module kvt_scan
    import kvt_pkg::*;
#(
    parameter int IDX_W = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             chk_valid,
    input  logic [IDX_W-1:0] chk_idx,
    input  logic             rd_used,
    input  logic [31:0]      rd_key,
    input  logic [31:0]      rd_value,
    input  logic [31:0]      key,
    output kvt_scan_t        status
);

    kvt_scan_t acc_reg;
    kvt_scan_t acc_next;
    logic      cur_hit;
    logic      cur_free;

    assign cur_hit  = chk_valid && rd_used && (rd_key == key);
    assign cur_free = chk_valid && !rd_used;

    always_comb
    begin
        acc_next = acc_reg;
        if (!acc_reg.hit && cur_hit)
        begin
            acc_next.hit       = 1'b1;
            acc_next.hit_idx   = KVT_IDX_MAX_W'(chk_idx);
            acc_next.hit_value = rd_value;
        end
        if (!acc_reg.free && cur_free)
        begin
            acc_next.free     = 1'b1;
            acc_next.free_idx = KVT_IDX_MAX_W'(chk_idx);
        end
    end

    assign status = acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (start)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

>>> verif/tb_key_value_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_value_table_top
// Self-checking bench for the bounded key/value table.
// A queue of commands feeds a stream driver. Each accepted item runs through
// a local table predictor, and the monitor checks every result against the
// oldest prediction. The run starts with directed cases: empty table, key and
// value extremes, the spare code, an add of a present key, a full table and a
// delete that frees a slot. Random phases follow over key pools of varying
// size, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_key_value_table_top;
    import kvt_pkg::*;

    localparam int          SLOTS     = 16;
    localparam logic [1:0]  CMD_SPARE = 2'd3;
    localparam int          SETTLE    = 2 * (SLOTS + 1) + 8;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] key;
        logic [31:0] val;
        bit          hold;
    } kv_item_t;

    typedef struct {
        logic        found;
        logic [31:0] data;
        logic        drop;
    } kv_result_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;   // key[31:0], value[63:32]
    logic [1:0]  s_axis_tuser  = '0;   // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // stored_value
    logic [1:0]  m_axis_tuser;          // found[0], full_drop[1]

    kv_item_t    pend_q[$];
    kv_result_t  result_q[$];
    kv_item_t    cur_item;
    kv_result_t  want;

    logic        tbl_used [SLOTS];
    logic [31:0] tbl_key  [SLOTS];
    logic [31:0] tbl_val  [SLOTS];

    int          total_items;
    int          n_sent;
    int          n_recv;
    int          gap_left;
    int          stall_left;
    int          errors;
    int          n_op [4];
    int          n_hit;
    int          n_drop;

    key_value_table_top #(.CAPACITY(SLOTS)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // table predictor: result from the state before the item, then update
    function automatic kv_result_t apply_to_table(kv_item_t it);
        kv_result_t r;
        int         hit;
        int         free_idx;
        r.found  = 1'b0;
        r.data   = '0;
        r.drop   = 1'b0;
        hit      = -1;
        free_idx = -1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (hit < 0 && tbl_used[i] && tbl_key[i] == it.key)
                hit = i;
            if (free_idx < 0 && !tbl_used[i])
                free_idx = i;
        end
        if (hit >= 0)
        begin
            r.found = 1'b1;
            r.data  = tbl_val[hit];
        end
        if (it.op == CMD_ADD && hit < 0)
        begin
            if (free_idx >= 0)
            begin
                tbl_used[free_idx] = 1'b1;
                tbl_key[free_idx]  = it.key;
                tbl_val[free_idx]  = it.val;
            end
            else
                r.drop = 1'b1;
        end
        else if (it.op == CMD_DELETE && hit >= 0)
            tbl_used[hit] = 1'b0;
        n_op[it.op]++;
        if (r.found)
            n_hit++;
        if (r.drop)
            n_drop++;
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] exp_val);
        errors++;
        $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, exp_val);
    endtask

    task automatic push_item(logic [1:0] op, logic [31:0] key, logic [31:0] val, bit hold);
        kv_item_t it;
        it.op   = op;
        it.key  = key;
        it.val  = val;
        it.hold = hold;
        pend_q.push_back(it);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                result_q.push_back(apply_to_table(cur_item));
                n_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pend_q.size() > 0 && !(pend_q[0].hold && result_q.size() != 0))
                begin
                    if (n_sent < total_items - 150 && (n_sent / 120) % 4 != 3
                        && $urandom_range(0, 3) == 0)
                    begin
                        gap_left = $urandom_range(0, 6);
                        s_axis_tvalid <= 1'b0;
                    end
                    else
                    begin
                        cur_item = pend_q.pop_front();
                        s_axis_tdata  <= {cur_item.val, cur_item.key};
                        s_axis_tuser  <= cur_item.op;
                        s_axis_tvalid <= 1'b1;
                    end
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor and result-side stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                n_recv++;
                if (result_q.size() == 0)
                    report("unexpected result", {m_axis_tuser, m_axis_tdata[29:0]}, '0);
                else
                begin
                    want = result_q.pop_front();
                    if (m_axis_tuser[0] !== want.found)
                        report("found", 32'(m_axis_tuser[0]), 32'(want.found));
                    if (m_axis_tdata !== want.data)
                        report("stored_value", m_axis_tdata, want.data);
                    if (m_axis_tuser[1] !== want.drop)
                        report("full_drop", 32'(m_axis_tuser[1]), 32'(want.drop));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (n_recv < total_items - 150 && (n_recv / 100) % 5 != 2
                     && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 6);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        int          pool_sizes [6];
        logic [31:0] key_pool [$];
        logic [31:0] k;
        logic [31:0] v;
        int          roll;
        pool_sizes = '{6, 20, 18, 40, 17, 24};
        errors = 0;
        n_sent = 0;
        n_recv = 0;
        n_hit  = 0;
        n_drop = 0;
        n_op   = '{0, 0, 0, 0};
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_used[i] = 1'b0;
            tbl_key[i]  = '0;
            tbl_val[i]  = '0;
        end

        // directed
        push_item(CMD_SEARCH, 32'h0000_0000, 32'h1234_5678, 1'b0);
        push_item(CMD_DELETE, 32'hFFFF_FFFF, 32'h0, 1'b0);
        push_item(CMD_ADD,    32'h0000_0000, 32'h8000_0000, 1'b0);
        push_item(CMD_ADD,    32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        push_item(CMD_SEARCH, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        push_item(CMD_SPARE,  32'hFFFF_FFFF, 32'h5555_5555, 1'b0);
        push_item(CMD_ADD,    32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        push_item(CMD_DELETE, 32'hFFFF_FFFF, 32'h0, 1'b0);
        push_item(CMD_SEARCH, 32'hFFFF_FFFF, 32'h0, 1'b0);
        for (int i = 1; i < SLOTS; i++)
            push_item(CMD_ADD, i, ~i, 1'b0);
        push_item(CMD_ADD,    32'hA5A5_A5A5, 32'h0F0F_0F0F, 1'b0);
        push_item(CMD_DELETE, 32'h0000_0007, 32'h0, 1'b0);
        push_item(CMD_ADD,    32'hA5A5_A5A5, 32'h0F0F_0F0F, 1'b0);

        // random phases over key pools; the first item of each waits for a drain
        foreach (pool_sizes[p])
        begin
            key_pool.delete();
            for (int i = 0; i < pool_sizes[p]; i++)
                key_pool.push_back($urandom());
            if (p % 2 == 1)
            begin
                key_pool[0] = 32'h0000_0000;
                key_pool[1] = 32'hFFFF_FFFF;
            end
            for (int n = 0; n < 250; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                    k = $urandom();
                else
                    k = key_pool[$urandom_range(0, pool_sizes[p] - 1)];
                case ($urandom_range(0, 15))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    default: v = $urandom();
                endcase
                roll = $urandom_range(0, 99);
                if (roll < 35)
                    push_item(CMD_ADD, k, v, n == 0);
                else if (roll < 60)
                    push_item(CMD_DELETE, k, v, n == 0);
                else if (roll < 95)
                    push_item(CMD_SEARCH, k, v, n == 0);
                else
                    push_item(CMD_SPARE, k, v, n == 0);
            end
        end
        total_items = pend_q.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pend_q.size() != 0 || s_axis_tvalid || result_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (result_q.size() != 0)
            report("missing results", result_q.size(), 0);
        $display("Ran %0d items: %0d search, %0d add, %0d delete, %0d spare code.",
                 n_sent, n_op[CMD_SEARCH], n_op[CMD_ADD], n_op[CMD_DELETE], n_op[CMD_SPARE]);
        $display("%0d results checked, %0d key hits, %0d adds dropped on a full table.",
                 n_recv, n_hit, n_drop);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("Timeout with %0d items sent and %0d results seen.", n_sent, n_recv);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
